// ----- design/hqs_pkg.sv -----
// Shared types and constants for the hybrid quicksort unit.
package hqs_pkg;

    localparam int unsigned VALUE_W = 32;

    typedef logic signed [VALUE_W-1:0] t_value;

    typedef enum logic [0:0] {
        ST_LOAD,
        ST_EMIT
    } t_state;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_cmd;

endpackage

// ----- design/hybrid_quicksort_unit.sv -----
// Batch sorter for signed 32-bit values built as a chain of insertion cells.
// Load: one beat per cycle; each accepted value drops straight into its place in the chain registers.
// Emit: after the tlast beat, one sorted beat per cycle (output register backpressure).
// A batch is loaded in full, then emitted in full; input stalls while emitting.
// Reset (i_rst_n low, synchronous) empties all cells and clears count and overflow.
module hybrid_quicksort_unit #(
    parameter int unsigned DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] value_res
    output logic        m_axis_tlast,   // last_res
    output logic [0:0]  m_axis_tuser    // [0] overflow
);
    import hqs_pkg::*;

    localparam int unsigned CW = $clog2(DEPTH + 1);

    t_state    r_state;
    t_state    n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic      r_dropped;
    logic      n_dropped;

    logic      r_m_valid;
    logic      n_m_valid;
    t_value    r_m_data;
    logic      r_m_last;
    logic      r_m_ovf;

    t_cell_cmd w_cmd;
    logic      w_in_beat;
    logic      w_pop;
    logic      w_full;

    t_value    w_value [DEPTH];
    logic [DEPTH-1:0] w_valid;
    logic [DEPTH-1:0] w_gt;

    assign w_full    = (r_count == CW'(DEPTH));
    assign w_in_beat = s_axis_tvalid && s_axis_tready;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: if (w_in_beat && s_axis_tlast) n_state = ST_EMIT;
            ST_EMIT: if (w_pop && r_count == CW'(1)) n_state = ST_LOAD;
            default: n_state = ST_LOAD;
        endcase
    end

    // ---------------- FSM outputs ----------------
    always_comb begin
        s_axis_tready = 1'b0;
        w_pop         = 1'b0;
        case (r_state)
            ST_LOAD: s_axis_tready = 1'b1;
            ST_EMIT: w_pop = !r_m_valid || m_axis_tready;
            default: begin
                s_axis_tready = 1'b0;
                w_pop         = 1'b0;
            end
        endcase
    end

    // insert only while room remains; a full store drops the beat
    assign w_cmd.insert = w_in_beat && !w_full;
    assign w_cmd.shift  = w_pop;

    // ---------------- count / overflow ----------------
    always_comb begin
        n_count   = r_count;
        n_dropped = r_dropped;
        if (w_in_beat) begin
            if (w_full) n_dropped = 1'b1;
            else        n_count   = r_count + CW'(1);
        end
        if (w_pop) begin
            n_count = r_count - CW'(1);
            if (r_count == CW'(1)) n_dropped = 1'b0;
        end
    end

    // output register: freed by the sink, refilled from the head cell
    always_comb begin
        n_m_valid = r_m_valid;
        if (m_axis_tready) n_m_valid = 1'b0;
        if (w_pop)         n_m_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_m_data <= w_value[0];
            r_m_last <= (r_count == CW'(1));
            r_m_ovf  <= r_dropped;
        end
    end

    // ---------------- cell chain ----------------
    // cell 0 holds the smallest value; empty cells sit at the tail
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        t_value w_pv;
        logic   w_pvld;
        logic   w_pgt;
        t_value w_nv;
        logic   w_nvld;

        if (gi == 0) begin : g_head
            assign w_pv   = '0;
            assign w_pvld = 1'b0;
            assign w_pgt  = 1'b0;
        end else begin : g_body
            assign w_pv   = w_value[gi-1];
            assign w_pvld = w_valid[gi-1];
            assign w_pgt  = w_gt[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_tail
            assign w_nv   = '0;
            assign w_nvld = 1'b0;
        end else begin : g_mid
            assign w_nv   = w_value[gi+1];
            assign w_nvld = w_valid[gi+1];
        end

        hqs_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_new_value  (s_axis_tdata),
            .i_prev_value (w_pv),
            .i_prev_valid (w_pvld),
            .i_prev_gt    (w_pgt),
            .i_next_value (w_nv),
            .i_next_valid (w_nvld),
            .o_value      (w_value[gi]),
            .o_valid      (w_valid[gi]),
            .o_gt         (w_gt[gi])
        );
    end

    assign m_axis_tvalid   = r_m_valid;
    assign m_axis_tdata    = r_m_data;
    assign m_axis_tlast    = r_m_last;
    assign m_axis_tuser[0] = r_m_ovf;

    // ---------------- assertions ----------------
    a_count_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("element count differs from occupied cells");

    a_emit_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (w_valid[0] && r_count != '0))
        else $error("emit state with empty chain");

    a_last_starts_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_beat && s_axis_tlast) |=> (r_state == ST_EMIT))
        else $error("last beat did not start emission");

    for (genvar ga = 0; ga < DEPTH - 1; ga++) begin : g_chk
        a_chain_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            w_valid[ga+1] |-> (w_valid[ga] && !(w_value[ga+1] < w_value[ga])))
            else $error("cell chain out of order");
    end

endmodule

// ----- design/hqs_cell.sv -----
// One sorting cell: holds one value, inserts in order or shifts toward the head.
module hqs_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hqs_pkg::t_cell_cmd i_cmd,
    input  hqs_pkg::t_value   i_new_value,
    input  hqs_pkg::t_value   i_prev_value,
    input  logic              i_prev_valid,
    input  logic              i_prev_gt,
    input  hqs_pkg::t_value   i_next_value,
    input  logic              i_next_valid,
    output hqs_pkg::t_value   o_value,
    output logic              o_valid,
    output logic              o_gt
);
    import hqs_pkg::*;

    t_value r_value;
    t_value n_value;
    logic   r_valid;
    logic   n_valid;

    // empty cell or strictly larger value: new value goes at or before here
    assign o_gt = !r_valid || (i_new_value < r_value);

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_cmd.insert && o_gt) begin
            if (i_prev_gt) begin
                n_value = i_prev_value;
                n_valid = i_prev_valid;
            end else begin
                n_value = i_new_value;
                n_valid = 1'b1;
            end
        end else if (i_cmd.shift) begin
            n_value = i_next_value;
            n_valid = i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_valid = r_valid;

endmodule

// ----- bench/tb_hybrid_quicksort_unit.sv -----
// Self-checking bench for the hybrid quicksort unit: batches in, sorted beats out.
module tb_hybrid_quicksort_unit;

    import hqs_pkg::*;

    localparam int STORE_DEPTH    = 64;
    localparam int HOLD_CYCLES    = 300;   // long sink stall, fills the unit
    localparam int DRAIN_CYCLES   = 80;    // > one full emit pass
    localparam int WATCHDOG_LIMIT = 20000; // cycles with no beat on either side
    localparam int RANDOM_ITEMS   = 240;
    localparam int IDLE_PCT       = 27;
    localparam int DIR_N          = 23;

    // one sorted output beat
    typedef struct packed {
        t_value value;
        logic   last;
        logic   ovf;
    } t_sorted_beat;

    // hand-written result for single-value batches
    typedef struct {
        bit     typed;
        t_value want;
        logic   want_ovf;
    } t_fixed_result;

    typedef struct {
        t_value value;
        logic   fin;
        bit     typed;
        t_value want;
        logic   want_ovf;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // [31:0] value
    logic        s_axis_tlast;   // last
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [31:0] value_res
    logic        m_axis_tlast;   // last_res
    logic [0:0]  m_axis_tuser;   // [0] overflow

    hybrid_quicksort_unit #(
        .DEPTH(STORE_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Directed part: extremes, duplicates, reversed order, single-value batches.
    // Single-value batches carry their result inline; the rest go through the model.
    t_dir_row dir_rows [DIR_N] = '{
        '{32'sh80000000, 1'b1, 1'b1, 32'sh80000000, 1'b0},
        '{32'sh7FFFFFFF, 1'b1, 1'b1, 32'sh7FFFFFFF, 1'b0},
        '{32'sh00000000, 1'b1, 1'b1, 32'sh00000000, 1'b0},
        '{32'shFFFFFFFF, 1'b1, 1'b1, 32'shFFFFFFFF, 1'b0},
        '{32'sh7FFFFFFF, 1'b0, 1'b0, 32'sh0, 1'b0},
        '{32'sh80000000, 1'b0, 1'b0, 32'sh0, 1'b0},
        '{32'sh00000000, 1'b0, 1'b0, 32'sh0, 1'b0},
        '{32'shFFFFFFFF, 1'b0, 1'b0, 32'sh0, 1'b0},
        '{32'sh00000001, 1'b0, 1'b0, 32'sh0, 1'b0},
        '{32'sh80000000, 1'b0, 1'b0, 32'sh0, 1'b0},
        '{32'sh7FFFFFFF, 1'b0, 1'b0, 32'sh0, 1'b0},
        '{32'sh12345678, 1'b1, 1'b0, 32'sh0, 1'b0},
        '{32'sh00000005, 1'b0, 1'b0, 32'sh0, 1'b0},
        '{32'sh00000004, 1'b0, 1'b0, 32'sh0, 1'b0},
        '{32'sh00000003, 1'b0, 1'b0, 32'sh0, 1'b0},
        '{32'sh00000002, 1'b0, 1'b0, 32'sh0, 1'b0},
        '{32'sh00000001, 1'b0, 1'b0, 32'sh0, 1'b0},
        '{32'shFFFFFFFA, 1'b1, 1'b0, 32'sh0, 1'b0},
        '{32'sh00000007, 1'b0, 1'b0, 32'sh0, 1'b0},
        '{32'sh00000007, 1'b1, 1'b0, 32'sh0, 1'b0},
        '{32'sh55555555, 1'b0, 1'b0, 32'sh0, 1'b0},
        '{32'shAAAAAAAA, 1'b0, 1'b0, 32'sh0, 1'b0},
        '{32'sh7FFFFFFE, 1'b1, 1'b0, 32'sh0, 1'b0}
    };

    // model state: values held for the open batch
    t_value held_vals [STORE_DEPTH];
    int     held_len  = 0;
    logic   held_over = 1'b0;

    t_sorted_beat  sorted_due[$];   // sorted beats still owed by the unit
    t_fixed_result row_notes[$];    // one per offered beat, in offer order

    int pending      = 0;  // sorted_due depth as seen by other processes (NBA)
    int results_seen = 0;
    int quiet        = 0;
    int errors       = 0;
    bit steady       = 1'b0; // no idling on either side while set

    // Adds one value to the open batch; on the last beat sorts the batch
    // ascending (signed, duplicates kept) and queues the owed beats.
    function automatic int predict_sorted(t_value v, logic fin, t_fixed_result note);
        t_value key;
        int     i;
        int     j;
        int     n;
        if (held_len < STORE_DEPTH) begin
            held_vals[held_len] = v;
            held_len++;
        end else begin
            held_over = 1'b1;    // store full: value dropped, even on last
        end
        if (!fin) return 0;
        for (i = 1; i < held_len; i++) begin
            key = held_vals[i];
            j = i - 1;
            while (j >= 0 && held_vals[j] > key) begin
                held_vals[j + 1] = held_vals[j];
                j--;
            end
            held_vals[j + 1] = key;
        end
        n = held_len;
        if (note.typed) begin
            sorted_due.push_back('{note.want, 1'b1, note.want_ovf});
        end else begin
            for (i = 0; i < n; i++)
                sorted_due.push_back('{held_vals[i], (i == n - 1), held_over});
        end
        held_len  = 0;
        held_over = 1'b0;
        return n;
    endfunction

    function automatic t_value pick_value();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 50) return t_value'($urandom);
        if (roll < 75) return t_value'($urandom_range(8)) - 4;   // dense, many repeats
        case ($urandom_range(5))
            0:       return 32'sh80000000;
            1:       return 32'sh7FFFFFFF;
            2:       return 32'sh00000000;
            3:       return 32'shFFFFFFFF;
            4:       return 32'sh80000001;
            default: return 32'sh7FFFFFFE;
        endcase
    endfunction

    // Offer one beat, with random gaps in front, and hold it until taken.
    task automatic offer_value(t_value v, logic fin, t_fixed_result note);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        row_notes.push_back(note);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    // Monitor: model update on input beats, compare on output beats, watchdog.
    always @(posedge i_clk) begin
        int           n_push;
        int           n_pop;
        bit           moved;
        t_sorted_beat want;
        n_push = 0;
        n_pop  = 0;
        moved  = 1'b0;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            moved  = 1'b1;
            n_push = predict_sorted(t_value'(s_axis_tdata), s_axis_tlast,
                                    row_notes.pop_front());
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            moved = 1'b1;
            if (sorted_due.size() == 0) begin
                $display("%0t: unexpected beat value %0d last %0b ovf %0b", $time,
                         $signed(m_axis_tdata), m_axis_tlast, m_axis_tuser[0]);
                errors++;
            end else begin
                want  = sorted_due.pop_front();
                n_pop = 1;
                if (t_value'(m_axis_tdata) !== want.value) begin
                    $display("%0t: value expected %0d actual %0d", $time,
                             want.value, $signed(m_axis_tdata));
                    errors++;
                end
                if (m_axis_tlast !== want.last) begin
                    $display("%0t: last expected %0b actual %0b", $time,
                             want.last, m_axis_tlast);
                    errors++;
                end
                if (m_axis_tuser[0] !== want.ovf) begin
                    $display("%0t: overflow expected %0b actual %0b", $time,
                             want.ovf, m_axis_tuser[0]);
                    errors++;
                end
            end
        end
        pending      <= pending + n_push - n_pop;
        results_seen <= results_seen + n_pop;
        quiet        <= moved ? 0 : quiet + 1;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, quiet);
            $display("Mismatches found");
            $finish;
        end
    end

    // Sink: random stalls, plus one long hold once results start flowing so
    // the unit backs up and stalls its input.
    initial begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (!hold_done && results_seen >= 30) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // Source: reset, directed table, full pause, random batches, drain.
    initial begin
        t_fixed_result no_note;
        int            r;
        int            k;
        int            batch_idx;
        int            sent;
        int            len;
        no_note = '{1'b0, 32'sh0, 1'b0};
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < DIR_N; r++)
            offer_value(dir_rows[r].value, dir_rows[r].fin,
                        '{dir_rows[r].typed, dir_rows[r].want, dir_rows[r].want_ovf});

        // hold off until the unit has delivered everything owed
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        // first two batches: exactly full, then overrun by two with the last two beats dropped
        batch_idx = 0;
        sent      = 0;
        while (sent < RANDOM_ITEMS) begin
            if (batch_idx == 0)
                len = STORE_DEPTH;
            else if (batch_idx == 1)
                len = STORE_DEPTH + 2;
            else if ($urandom_range(99) < 80)
                len = $urandom_range(16, 1);
            else
                len = $urandom_range(48, 17);
            steady <= (batch_idx >= 3 && batch_idx <= 7);
            for (k = 0; k < len; k++)
                offer_value(pick_value(), (k == len - 1), no_note);
            sent += len;
            batch_idx++;
        end

        s_axis_tvalid <= 1'b0;
        steady        <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0 && sorted_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
